>>> hw/rtl/nbc_pkg.sv
// ---------------------------------------------------------------------------
// nbc_pkg: shared types and constants for the NLFSR block cipher
// Round function, nonlinear table and the control bundle passed between cells.
// ---------------------------------------------------------------------------
package nbc_pkg;

	localparam int BLOCK_W = 32;
	localparam int KEY_W   = 32;
	localparam int KIDX_W  = 5;

	// Nonlinear function, indexed by five tap bits
	localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	// Control that travels alongside each block through the cell row
	typedef struct packed {
		logic valid;
		op_t  op;
	} cell_ctl_t;

	// One round in either direction; kb is the key bit for this round
	function automatic logic [BLOCK_W-1:0] nbc_round(
		input op_t               op,
		input logic [BLOCK_W-1:0] x,
		input logic              kb
	);
		logic [4:0] idx;
		logic       b;
		logic [BLOCK_W-1:0] res;
		if (op == OP_ENCRYPT) begin
			idx = {x[31], x[26], x[20], x[9], x[1]};
			b   = x[0] ^ x[16] ^ NLF_TABLE[idx] ^ kb;
			res = {b, x[BLOCK_W-1:1]};
		end else begin
			idx = {x[30], x[25], x[19], x[8], x[0]};
			b   = x[31] ^ x[15] ^ NLF_TABLE[idx] ^ kb;
			res = {x[BLOCK_W-2:0], b};
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/nlfsr_block_cipher_32_top.sv
// ---------------------------------------------------------------------------
// nlfsr_block_cipher_32_top: NLFSR 32-bit block cipher, fully unrolled
// A row of ROUND_COUNT round cells; one block enters per clock.
// ---------------------------------------------------------------------------
// Usage: pulse start with op and block_in to launch a beat; the block is
// taken on every edge where start is high, busy never rises, so a new beat
// may follow in every cycle. Each beat passes through one round cell per
// clock, so its result appears on block_out with done high once it
// leaves the last of the ROUND_COUNT cells, and beats leave in the order
// they came in, one per cycle at most. The receiver
// cannot stall: done is a one-cycle strobe and block_out is only valid in
// that cycle. Each cell does one round and has one output register.
// The key half is written over the cfg_valid/cfg_ready
// channel (always ready) and must only change while no beat is in flight.
// ---------------------------------------------------------------------------
module nlfsr_block_cipher_32_top #(
	parameter int ROUND_COUNT = 528
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [nbc_pkg::BLOCK_W-1:0] block_in,
	// result side
	output logic                        done,
	output logic [nbc_pkg::BLOCK_W-1:0] block_out,
	// key configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [nbc_pkg::KEY_W-1:0]   half_key
);
	import nbc_pkg::*;

	logic [KEY_W-1:0] half_key_q;

	// Stage k carries the beat after k rounds; stage 0 is the command port
	cell_ctl_t          ctl [ROUND_COUNT+1];
	logic [BLOCK_W-1:0] blk [ROUND_COUNT+1];

	// The pipeline never refuses a beat, and key writes are always taken
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold the key half; it feeds every cell directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			half_key_q <= half_key;
		end
	end

	assign ctl[0].valid = start && !busy;
	assign ctl[0].op    = op_t'(op);
	assign blk[0]       = block_in;

	// Round cells: cell g performs round g
	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
		nbc_round_cell #(
			.ROUND(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.half_key(half_key_q),
			.ctl_in  (ctl[g]),
			.blk_in  (blk[g]),
			.ctl_out (ctl[g+1]),
			.blk_out (blk[g+1])
		);
	end

	// Present the last cell's register as the result strobe
	assign done      = ctl[ROUND_COUNT].valid;
	assign block_out = blk[ROUND_COUNT];

endmodule

>>> hw/rtl/nbc_round_cell.sv
// ---------------------------------------------------------------------------
// nbc_round_cell: one cipher round with its own output register
// Applies a single round and hands the block to the next cell every cycle.
// ---------------------------------------------------------------------------
module nbc_round_cell #(
	parameter int ROUND = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [nbc_pkg::KEY_W-1:0]   half_key,
	input  nbc_pkg::cell_ctl_t          ctl_in,
	input  logic [nbc_pkg::BLOCK_W-1:0] blk_in,
	output nbc_pkg::cell_ctl_t          ctl_out,
	output logic [nbc_pkg::BLOCK_W-1:0] blk_out
);
	import nbc_pkg::*;

	// Key bit positions for this round, fixed at elaboration
	localparam logic [KIDX_W-1:0] ENC_KIDX = KIDX_W'(ROUND % KEY_W);
	localparam logic [KIDX_W-1:0] DEC_KIDX = KIDX_W'((15 - (ROUND % KEY_W) + KEY_W) % KEY_W);

	logic              kb;
	logic              valid_q;
	op_t               op_q;
	logic [BLOCK_W-1:0] blk_q;

	assign kb = (ctl_in.op == OP_ENCRYPT) ? half_key[ENC_KIDX] : half_key[DEC_KIDX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctl_in.valid;
		end
	end

	// Payload advances every cycle; no reset needed
	always_ff @(posedge clk) begin
		op_q  <= ctl_in.op;
		blk_q <= nbc_round(ctl_in.op, blk_in, kb);
	end

	assign ctl_out.valid = valid_q;
	assign ctl_out.op    = op_q;
	assign blk_out       = blk_q;

endmodule
